@@ rtl/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, off while reset is high
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check on the rising clock edge, live through reset as well
`define CHK_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/cmwc_pkg.sv @@
package cmwc_pkg;

  // default lag table depth
  localparam int CMWC_TABLE_DEPTH = 4096;

  // multiplier, base and reset words of the generator
  localparam logic [15:0] CMWC_MULT        = 16'd18782;
  localparam logic [31:0] CMWC_BASE        = 32'hffff_fffe;
  localparam logic [31:0] CMWC_CARRY_RESET = 32'd362436;
  localparam logic [31:0] CMWC_PHI_RESET   = 32'h9e37_79b9;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIN,
    ST_SEED
  } ctrl_state_t;

endpackage

@@ rtl/cmwc_random_generator_unit.sv @@
// Complementary multiply-with-carry generator with a TABLE_DEPTH-word lag table in one
// synchronous RAM. A draw (req_type 0) is accepted when start is high and busy is low;
// its word appears on random_word with result_strobe high for one cycle, after the RAM
// read register, the multiply-add register and the result register. The receiver
// cannot stall, so every strobe must be taken.
// Busy is high while the RAM read data goes through the multiply-add register, and low
// again in the write-back state, where the next draw may be accepted. A seed (req_type 1)
// rewrites the whole table one word a cycle and holds busy high until its last word is
// written; it gives no result and keeps index and carry. Draws before the first seed
// return undefined words. The user must write phi_word through cfg_valid/cfg_data
// (always ready) only while the block is idle; the block itself does not enforce this.
module cmwc_random_generator_unit #(
  parameter int TABLE_DEPTH = cmwc_pkg::CMWC_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [31:0] seed_value,
  output logic        result_strobe,
  output logic [31:0] random_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int IW = $clog2(TABLE_DEPTH);

  cmwc_pkg::ctrl_state_t state, state_next;

  logic [31:0]   phi_word;
  logic [IW-1:0] table_index;
  logic [IW-1:0] index_inc;
  logic [31:0]   carry_word;
  logic          accept;
  logic          seed_go;
  logic          seed_we;
  logic [IW-1:0] seed_addr;
  logic [31:0]   seed_data;
  logic          seed_last;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [31:0]   mem_rdata;
  logic [31:0]   draw_x;
  logic [31:0]   carry_next;

  assign cfg_ready = 1'b1;
  assign busy      = (state == cmwc_pkg::ST_MUL) || (state == cmwc_pkg::ST_SEED);
  assign accept    = start && !busy;
  assign seed_go   = accept && req_type;
  assign index_inc = (table_index == IW'(TABLE_DEPTH - 1)) ? '0 : table_index + 1'b1;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmwc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cmwc_pkg::ST_IDLE, cmwc_pkg::ST_FIN: begin
        if (accept) begin
          state_next = req_type ? cmwc_pkg::ST_SEED : cmwc_pkg::ST_MUL;
        end else begin
          state_next = cmwc_pkg::ST_IDLE;
        end
      end
      cmwc_pkg::ST_MUL: begin
        state_next = cmwc_pkg::ST_FIN;
      end
      cmwc_pkg::ST_SEED: begin
        if (seed_last) begin
          state_next = cmwc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cmwc_pkg::ST_IDLE;
      end
    endcase
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      phi_word <= cmwc_pkg::CMWC_PHI_RESET;
    end else if (cfg_valid && cfg_ready) begin
      phi_word <= cfg_data;
    end
  end

  // index advances on draw transfer, carry on write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      table_index <= IW'(TABLE_DEPTH - 1);
      carry_word  <= cmwc_pkg::CMWC_CARRY_RESET;
    end else begin
      if (accept && !req_type) begin
        table_index <= index_inc;
      end
      if (state == cmwc_pkg::ST_FIN) begin
        carry_word <= carry_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (state == cmwc_pkg::ST_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (state == cmwc_pkg::ST_FIN) begin
      random_word <= draw_x;
    end
  end

  // write port shared by the write-back and the seed sweep
  always_comb begin
    if (state == cmwc_pkg::ST_FIN) begin
      mem_we    = 1'b1;
      mem_waddr = table_index;
      mem_wdata = draw_x;
    end else begin
      mem_we    = seed_we;
      mem_waddr = seed_addr;
      mem_wdata = seed_data;
    end
  end

  cmwc_lag_mem #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(index_inc),
    .rdata(mem_rdata)
  );

  cmwc_seed_fill #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_seed (
    .clk  (clk),
    .rst  (rst),
    .go   (seed_go),
    .seed (seed_value),
    .phi  (phi_word),
    .we   (seed_we),
    .waddr(seed_addr),
    .wdata(seed_data),
    .last (seed_last)
  );

  cmwc_draw_unit u_draw (
    .clk       (clk),
    .load      (state == cmwc_pkg::ST_MUL),
    .word      (mem_rdata),
    .carry     (carry_word),
    .x         (draw_x),
    .carry_next(carry_next)
  );

endmodule

@@ rtl/cmwc_lag_mem.sv @@
module cmwc_lag_mem #(
  parameter int TABLE_DEPTH = cmwc_pkg::CMWC_TABLE_DEPTH,
  localparam int IW = $clog2(TABLE_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [IW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [TABLE_DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/cmwc_seed_fill.sv @@
module cmwc_seed_fill #(
  parameter int TABLE_DEPTH = cmwc_pkg::CMWC_TABLE_DEPTH,
  localparam int IW = $clog2(TABLE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [31:0]   seed,
  input  logic [31:0]   phi,
  output logic          we,
  output logic [IW-1:0] waddr,
  output logic [31:0]   wdata,
  output logic          last
);

  logic          active;
  logic [IW-1:0] k;
  logic [31:0]   seed_q;
  logic [31:0]   w3;
  logic [31:0]   w2;
  logic [31:0]   w1;

  // word for the current position
  always_comb begin
    if (k == IW'(0)) begin
      wdata = seed_q;
    end else if (k == IW'(1)) begin
      wdata = seed_q + phi;
    end else if (k == IW'(2)) begin
      wdata = seed_q + {phi[30:0], 1'b0};
    end else begin
      wdata = w3 ^ w2 ^ phi ^ {{(32-IW){1'b0}}, k};
    end
  end

  assign we    = active;
  assign waddr = k;
  assign last  = active && (k == IW'(TABLE_DEPTH - 1));

  // sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      k      <= '0;
    end else if (go) begin
      active <= 1'b1;
      k      <= '0;
    end else if (active) begin
      if (last) begin
        active <= 1'b0;
      end
      k <= k + 1'b1;
    end
  end

  // seed word and the last three words written
  always_ff @(posedge clk) begin
    if (go) begin
      seed_q <= seed;
    end
    if (active) begin
      w3 <= w2;
      w2 <= w1;
      w1 <= wdata;
    end
  end

endmodule

@@ rtl/cmwc_draw_unit.sv @@
module cmwc_draw_unit (
  input  logic        clk,
  input  logic        load,
  input  logic [31:0] word,
  input  logic [31:0] carry,
  output logic [31:0] x,
  output logic [31:0] carry_next
);

  logic [47:0] prod;
  logic [31:0] hi;
  logic [32:0] sum;
  logic        co;

  // multiply-add stage
  always_ff @(posedge clk) begin
    if (load) begin
      prod <= 48'(cmwc_pkg::CMWC_MULT) * 48'(word) + 48'(carry);
    end
  end

  // carry fold and complement
  assign hi         = {16'd0, prod[47:32]};
  assign sum        = {1'b0, prod[31:0]} + {1'b0, hi};
  assign co         = sum[32];
  assign x          = cmwc_pkg::CMWC_BASE - sum[31:0] - {31'd0, co};
  assign carry_next = hi + {31'd0, co};

endmodule

@@ rtl/cmwc_checker.sv @@
`include "assert_macros.svh"

module cmwc_prop_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic req_type,
  input logic result_strobe
);

  logic draw_xfer;
  logic seed_xfer;

  assign draw_xfer = start && !busy && !req_type;
  assign seed_xfer = start && !busy && req_type;

  // every draw transfer yields a result strobe
  `CHK_ASSERT(a_draw_result, clk, rst, draw_xfer |-> ##3 result_strobe, "draw lost its result")

  // no result without an earlier draw transfer
  `CHK_ASSERT(a_no_phantom, clk, rst, result_strobe |-> $past(draw_xfer, 3), "result without draw")

  // a seed sweep holds the block busy
  `CHK_ASSERT(a_seed_busy, clk, rst, seed_xfer |=> busy ##1 busy, "seed sweep not busy")

  // draws are spaced, so strobes never come back to back
  `CHK_ASSERT(a_strobe_gap, clk, rst, result_strobe |=> !result_strobe, "strobe held two cycles")

  // reset leaves the block idle with no result showing
  `CHK_ASSERT_ALL(a_reset_quiet, clk, rst |=> !busy && !result_strobe, "not quiet after reset")

endmodule

bind cmwc_random_generator_unit cmwc_prop_checker u_chk (.*);
